// ===== hw/rtl/gae_pkg.sv =====
package gae_pkg;

	// Field widths of the sample and result transactions.
	localparam int ENV_W = 4;
	localparam int VAL_W = 32;
	localparam int FRAC_W = 16;

	// Environment count default and the most environments the index can address.
	localparam int ENV_COUNT_DEF = 16;
	localparam int ENV_SLOTS_MAX = 1 << ENV_W;

	// Work queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Internal arithmetic widths: rounded products, the TD error and the carry sum.
	localparam int PROD_W = VAL_W + 1;
	localparam int DELTA_W = VAL_W + 2;
	localparam int SUM_W = VAL_W + 3;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic {
		REG_DISCOUNT = 1'b0,
		REG_TRACE_DECAY = 1'b1
	} gae_reg_t;

	localparam logic [FRAC_W-1:0] DISCOUNT_RESET = 16'd64881;
	localparam logic [FRAC_W-1:0] TRACE_DECAY_RESET = 16'd62259;
	localparam logic [2*FRAC_W:0] GL_PROD_RESET =
		(2*FRAC_W+1)'(DISCOUNT_RESET) * (2*FRAC_W+1)'(TRACE_DECAY_RESET);
	localparam logic [FRAC_W-1:0] GL_RESET =
		FRAC_W'((GL_PROD_RESET + (2*FRAC_W+1)'(33'h8000)) >> FRAC_W);

	typedef struct packed {
		logic [ENV_W-1:0] env_index;
		logic [VAL_W-1:0] reward;
		logic [VAL_W-1:0] state_value;
		logic [VAL_W-1:0] next_state_value;
		logic terminated;
		logic truncated;
		logic rollout_end;
	} gae_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] advantage;
		logic saturated;
	} gae_out_t;

	// One queued work entry: the TD error plus what the carry stage needs.
	typedef struct packed {
		logic [ENV_W-1:0] env_index;
		logic [DELTA_W-1:0] delta;
		logic no_carry;
	} gae_work_t;

	// Unsigned Q0.16 fraction times signed Q16.16, rounded half up to Q16.16.
	function automatic logic [PROD_W-1:0] mul_round(input logic [FRAC_W-1:0] frac,
			input logic [VAL_W-1:0] x);
		logic signed [FRAC_W+VAL_W:0] p;
		p = $signed({1'b0, frac}) * $signed(x);
		p = p + (FRAC_W+VAL_W+1)'(32'h8000);
		return p[FRAC_W+VAL_W:FRAC_W];
	endfunction

endpackage

// ===== hw/rtl/gae_front.sv =====
module gae_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  gae_pkg::gae_in_t           sample,
	input  logic [gae_pkg::FRAC_W-1:0] discount,
	input  logic [gae_pkg::QCNT_W-1:0] q_count,
	output logic                       push,
	output gae_pkg::gae_work_t         push_data
);
	import gae_pkg::*;

	logic              valid_s1;
	logic [ENV_W-1:0]  env_s1;
	logic [PROD_W-1:0] rv_s1;
	logic [PROD_W-1:0] gn_s1;
	logic              term_s1;
	logic              trunc_s1;
	logic              last_s1;
	logic [QCNT_W:0]   occupancy;
	logic              accept;
	logic [DELTA_W-1:0] gn_term;

	// Credit check: queued entries plus the one in flight must leave a free slot.
	assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(valid_s1);
	assign sample_ready = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Reward minus value and the rounded discounted bootstrap, side by side.
	always_ff @(posedge clk) begin
		if (accept) begin
			env_s1 <= sample.env_index;
			rv_s1 <= {sample.reward[VAL_W-1], sample.reward}
				- {sample.state_value[VAL_W-1], sample.state_value};
			gn_s1 <= mul_round(discount, sample.next_state_value);
			term_s1 <= sample.terminated;
			trunc_s1 <= sample.truncated;
			last_s1 <= sample.rollout_end;
		end
	end

	// TD error: no bootstrap when terminated, forced to zero when truncated.
	assign gn_term = term_s1 ? '0 : {gn_s1[PROD_W-1], gn_s1};

	always_comb begin
		push = valid_s1;
		push_data.env_index = env_s1;
		push_data.no_carry = term_s1 || trunc_s1 || last_s1;
		if (trunc_s1) begin
			push_data.delta = '0;
		end else begin
			push_data.delta = {rv_s1[PROD_W-1], rv_s1} + gn_term;
		end
	end

endmodule

// ===== hw/rtl/gae_queue.sv =====
module gae_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  gae_pkg::gae_work_t         push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output gae_pkg::gae_work_t         head,
	output logic [gae_pkg::QCNT_W-1:0] count
);
	import gae_pkg::*;

	gae_work_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_valid = count_q != '0;
	assign head = entry_q[rd_ptr_q];
	assign count = count_q;

	// Pointers and fill count; the front end never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/gae_back.sv =====
module gae_back #(
	parameter int ENV_COUNT = gae_pkg::ENV_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  gae_pkg::gae_work_t         head,
	output logic                       pop,
	input  logic [gae_pkg::FRAC_W-1:0] gl_factor,
	output logic                       result_valid,
	input  logic                       result_ready,
	output gae_pkg::gae_out_t          result
);
	import gae_pkg::*;

	localparam int SLOTS = (ENV_COUNT < ENV_SLOTS_MAX) ? ENV_COUNT : ENV_SLOTS_MAX;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [VAL_W-1:0]  running_q [SLOTS];
	logic              out_valid_q;
	gae_out_t          out_q;
	logic              env_ok;
	logic [IDX_W-1:0]  slot;
	logic [PROD_W-1:0] carry;
	logic [SUM_W-1:0]  sum;
	logic              sat_hi;
	logic              sat_lo;
	gae_out_t          next_out;

	assign pop = head_valid && (!out_valid_q || result_ready);
	assign env_ok = 32'(head.env_index) < 32'(ENV_COUNT);
	assign slot = head.env_index[IDX_W-1:0];

	// Carry of the stored running advantage, scaled by gamma*lambda.
	always_comb begin
		if (env_ok && !head.no_carry) begin
			carry = mul_round(gl_factor, running_q[slot]);
		end else begin
			carry = '0;
		end
		sum = {head.delta[DELTA_W-1], head.delta} + {{2{carry[PROD_W-1]}}, carry};
	end

	// Clamp to signed Q16.16 and flag the clamp.
	always_comb begin
		sat_hi = !sum[SUM_W-1] && (sum[SUM_W-2:VAL_W-1] != '0);
		sat_lo = sum[SUM_W-1] && (sum[SUM_W-2:VAL_W-1] != '1);
		next_out.saturated = sat_hi || sat_lo;
		if (sat_hi) begin
			next_out.advantage = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (sat_lo) begin
			next_out.advantage = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			next_out.advantage = sum[VAL_W-1:0];
		end
	end

	// Per-environment running advantage, written back as the result enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				running_q[i] <= '0;
			end
		end else if (pop && env_ok) begin
			running_q[slot] <= next_out.advantage;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= next_out;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// ===== hw/rtl/gae_advantage_scan.sv =====
// A result passes through the front-end stage register, the work queue and the output register.
// Throughput: one sample per cycle while the work queue has a free slot and results are taken;
// the back end's carry multiply and add are combinational, feeding the running-advantage write-back.
// The four-entry work queue lets the front end keep accepting while results wait.
// Reset (arst_n low) clears all running advantages and restores gamma, lambda and their product.
module gae_advantage_scan #(
	parameter int ENV_COUNT = gae_pkg::ENV_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  gae_pkg::gae_in_t           sample,
	output logic                       result_valid,
	input  logic                       result_ready,
	output gae_pkg::gae_out_t          result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gae_pkg::ADDR_W-1:0] paddr,
	input  logic [gae_pkg::DATA_W-1:0] pwdata,
	output logic [gae_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import gae_pkg::*;

	logic [FRAC_W-1:0]   discount_q;
	logic [FRAC_W-1:0]   trace_decay_q;
	logic [FRAC_W-1:0]   gl_q;
	logic                cfg_write;
	logic                reg_sel;
	logic [FRAC_W-1:0]   new_discount;
	logic [FRAC_W-1:0]   new_trace_decay;
	logic [2*FRAC_W:0]   gl_prod;
	logic                push;
	gae_work_t           push_data;
	logic                pop;
	logic                head_valid;
	gae_work_t           head;
	logic [QCNT_W-1:0]   q_count;

	// Configuration registers; gamma*lambda is formed on every write.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_sel = paddr[2];
	assign new_discount = (reg_sel == REG_DISCOUNT) ? pwdata[FRAC_W-1:0] : discount_q;
	assign new_trace_decay = (reg_sel == REG_TRACE_DECAY) ? pwdata[FRAC_W-1:0] : trace_decay_q;
	assign gl_prod = (2*FRAC_W+1)'(new_discount) * (2*FRAC_W+1)'(new_trace_decay)
		+ (2*FRAC_W+1)'(33'h8000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q <= DISCOUNT_RESET;
			trace_decay_q <= TRACE_DECAY_RESET;
			gl_q <= GL_RESET;
		end else if (cfg_write) begin
			discount_q <= new_discount;
			trace_decay_q <= new_trace_decay;
			gl_q <= gl_prod[2*FRAC_W-1:FRAC_W];
		end
	end

	// Register readback.
	always_comb begin
		if (reg_sel == REG_TRACE_DECAY) begin
			prdata = DATA_W'(trace_decay_q);
		end else begin
			prdata = DATA_W'(discount_q);
		end
	end

	gae_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.discount    (discount_q),
		.q_count     (q_count),
		.push        (push),
		.push_data   (push_data)
	);

	gae_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head),
		.count     (q_count)
	);

	gae_back #(
		.ENV_COUNT(ENV_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.gl_factor   (gl_q),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

// ===== hw/rtl/gae_advantage_scan_checker.sv =====
module gae_advantage_scan_sva (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       result_valid,
	input logic                       result_ready,
	input gae_pkg::gae_out_t          result,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [gae_pkg::ADDR_W-1:0] paddr,
	input logic [gae_pkg::DATA_W-1:0] pwdata,
	input logic [gae_pkg::DATA_W-1:0] prdata,
	input logic                       pready
);
	import gae_pkg::*;

	// The register port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// A stalled result transaction holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A clamped result sits exactly at one end of the range.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |->
		(result.advantage == 32'h7fff_ffff || result.advantage == 32'h8000_0000))
		else $error("saturated result not at a range limit");

	// A discount write reads back its low sixteen bits on the next cycle.
	a_discount_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == REG_DISCOUNT) |=>
		(paddr[2] != REG_DISCOUNT) || (prdata == {16'h0000, $past(pwdata[15:0])}))
		else $error("discount readback mismatch");

endmodule

bind gae_advantage_scan gae_advantage_scan_sva u_checker (.*);

// ===== verif/gae_advantage_scan_checker.sv =====
// Watches the sample, result and register transactions of gae_advantage_scan,
// predicts each advantage estimate and compares it with what the block returns.
module gae_advantage_scan_checker #(
	parameter int ENV_COUNT = gae_pkg::ENV_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	input  logic                       sample_ready,
	input  gae_pkg::gae_in_t           sample,
	input  logic                       result_valid,
	input  logic                       result_ready,
	input  gae_pkg::gae_out_t          result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gae_pkg::ADDR_W-1:0] paddr,
	input  logic [gae_pkg::DATA_W-1:0] pwdata,
	input  logic [gae_pkg::DATA_W-1:0] prdata,
	input  logic                       pready,
	output int                         mismatch_count,
	output int                         outstanding,
	output int                         results_checked
);
	import gae_pkg::*;

	localparam longint ADV_MAX = 64'sd2147483647;
	localparam longint ADV_MIN = -64'sd2147483648;

	// Shadow copy of the registers, the gamma*lambda product and the carry store.
	logic [FRAC_W-1:0] gamma_q;
	logic [FRAC_W-1:0] lambda_q;
	logic [FRAC_W-1:0] gl_q;
	logic signed [VAL_W-1:0] running_adv [ENV_COUNT];
	gae_out_t expected_advantages [$];

	// Unsigned Q0.16 fraction times a Q16.16 value, rounded half up.
	function automatic longint scale_round(input logic [FRAC_W-1:0] frac, input longint x);
		longint p;
		p = longint'(frac) * x + 64'sh8000;
		return p >>> FRAC_W;
	endfunction

	function automatic logic [FRAC_W-1:0] trace_product(input logic [FRAC_W-1:0] g,
			input logic [FRAC_W-1:0] l);
		longint p;
		p = longint'(g) * longint'(l) + 64'sh8000;
		return FRAC_W'(p >> FRAC_W);
	endfunction

	// TD error plus the discounted carry of this environment, clamped to Q16.16.
	function automatic gae_out_t estimate_advantage(input gae_in_t s);
		longint delta;
		longint adv;
		gae_out_t r;
		delta = longint'($signed(s.reward)) - longint'($signed(s.state_value));
		if (!s.terminated)
			delta += scale_round(gamma_q, longint'($signed(s.next_state_value)));
		if (s.truncated)
			delta = 0;
		adv = delta;
		if (int'(s.env_index) < ENV_COUNT && !s.terminated && !s.truncated && !s.rollout_end)
			adv += scale_round(gl_q, longint'(running_adv[s.env_index]));
		r.saturated = 1'b1;
		if (adv > ADV_MAX)
			r.advantage = 32'h7FFF_FFFF;
		else if (adv < ADV_MIN)
			r.advantage = 32'h8000_0000;
		else begin
			r.advantage = VAL_W'(adv);
			r.saturated = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] register_value(input int idx);
		case (idx)
			int'(REG_DISCOUNT): return DATA_W'(gamma_q);
			int'(REG_TRACE_DECAY): return DATA_W'(lambda_q);
			default: return '0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		gae_out_t predicted;
		gae_out_t oldest;
		int reg_idx;
		if (!arst_n) begin
			gamma_q = DISCOUNT_RESET;
			lambda_q = TRACE_DECAY_RESET;
			gl_q = trace_product(DISCOUNT_RESET, TRACE_DECAY_RESET);
			foreach (running_adv[i])
				running_adv[i] = '0;
			expected_advantages.delete();
			outstanding = 0;
		end else begin
			reg_idx = int'(paddr) >> 2;

			// Register writes take effect at the access edge; reads must return the shadow.
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx)
						int'(REG_DISCOUNT): gamma_q = pwdata[FRAC_W-1:0];
						int'(REG_TRACE_DECAY): lambda_q = pwdata[FRAC_W-1:0];
						default: ;
					endcase
					gl_q = trace_product(gamma_q, lambda_q);
				end else if (reg_idx <= int'(REG_TRACE_DECAY)) begin
					if (prdata !== register_value(reg_idx)) begin
						$error("prdata: expected %h, got %h", register_value(reg_idx), prdata);
						mismatch_count++;
					end
				end
			end

			// Each result transaction is matched against the oldest prediction.
			if (result_valid && result_ready) begin
				if (expected_advantages.size() == 0) begin
					$error("result transaction with no sample waiting: advantage %h", result.advantage);
					mismatch_count++;
				end else begin
					oldest = expected_advantages.pop_front();
					results_checked++;
					if (result.advantage !== oldest.advantage) begin
						$error("advantage: expected %h, got %h", oldest.advantage, result.advantage);
						mismatch_count++;
					end
					if (result.saturated !== oldest.saturated) begin
						$error("saturated: expected %b, got %b", oldest.saturated, result.saturated);
						mismatch_count++;
					end
				end
			end

			// Predict each accepted sample and update the carry of its environment.
			if (sample_valid && sample_ready) begin
				predicted = estimate_advantage(sample);
				if (int'(sample.env_index) < ENV_COUNT)
					running_adv[sample.env_index] = predicted.advantage;
				expected_advantages.push_back(predicted);
			end

			outstanding = expected_advantages.size();
		end
	end

endmodule

// ===== verif/gae_advantage_scan_tb.sv =====
module gae_advantage_scan_tb;
	import gae_pkg::*;

	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 236;
	localparam int HOLDOFF_CYCLES = 64;
	localparam int BURST_ITEMS = 40;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 1_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	gae_in_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	gae_out_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	int mismatch_count;
	int outstanding;
	int results_checked;

	int cycle_count = 0;
	int samples_sent = 0;
	int settings_used = 1;
	int drains = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit holdoff_req = 1'b0;

	// Rollout bookkeeping per environment, used to build well-formed reverse-time streams.
	bit rollout_open [ENV_SLOTS_MAX];
	logic [VAL_W-1:0] last_value [ENV_SLOTS_MAX];
	int prev_env = 0;

	gae_advantage_scan dut (.*);

	gae_advantage_scan_checker checker_i (.*);

	always #4 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly moderate Q16.16 values, with full-width and boundary values mixed in.
	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		logic [VAL_W-1:0] v;
		r = $urandom_range(0, 99);
		v = $urandom;
		if (r < 65)
			v = $signed(v) >>> $urandom_range(6, 14);
		else if (r >= 80 && r < 90) begin
			case ($urandom_range(0, 3))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = '0;
				default: v = '1;
			endcase
		end else if (r >= 90)
			v = $signed(VAL_W'($urandom_range(0, 8))) <<< FRAC_W;
		return v;
	endfunction

	function automatic gae_in_t make_sample(input int env, input logic [VAL_W-1:0] rwd,
			input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] nxt,
			input logic term, input logic trunc, input logic last);
		gae_in_t s;
		s.env_index = ENV_W'(env);
		s.reward = rwd;
		s.state_value = val;
		s.next_state_value = nxt;
		s.terminated = term;
		s.truncated = trunc;
		s.rollout_end = last;
		return s;
	endfunction

	// Next step back in time of some environment's rollout.
	function automatic gae_in_t rollout_sample();
		gae_in_t s;
		int env;
		if ($urandom_range(0, 99) < 35)
			env = prev_env;
		else
			env = $urandom_range(0, ENV_COUNT_DEF - 1);
		s.env_index = ENV_W'(env);
		s.reward = pick_value();
		s.state_value = pick_value();
		s.terminated = ($urandom_range(0, 99) < 8);
		s.truncated = ($urandom_range(0, 99) < 4);
		s.rollout_end = !rollout_open[env] || ($urandom_range(0, 99) < 3);
		// The previously sent sample of this environment is the following state.
		if (!s.rollout_end && $urandom_range(0, 4) != 0)
			s.next_state_value = last_value[env];
		else
			s.next_state_value = pick_value();
		rollout_open[env] = 1'b1;
		last_value[env] = s.state_value;
		prev_env = env;
		return s;
	endfunction

	function automatic gae_in_t noise_sample();
		return make_sample(int'($urandom_range(0, ENV_SLOTS_MAX - 1)), $urandom, $urandom,
			$urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_sample(input gae_in_t s, input int gap);
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample = s;
		sample_valid = 1'b1;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic apb_access(input logic write, input gae_reg_t idx, input logic [DATA_W-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = write;
		paddr = ADDR_W'(int'(idx) * 4);
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Load gamma and lambda with junk in the upper data bits, then read both back.
	task automatic set_gains(input logic [FRAC_W-1:0] g, input logic [FRAC_W-1:0] l);
		logic [DATA_W-1:0] data;
		data = $urandom;
		data[FRAC_W-1:0] = g;
		apb_access(1'b1, REG_DISCOUNT, data);
		data = $urandom;
		data[FRAC_W-1:0] = l;
		apb_access(1'b1, REG_TRACE_DECAY, data);
		apb_access(1'b0, REG_DISCOUNT, '0);
		apb_access(1'b0, REG_TRACE_DECAY, '0);
		settings_used++;
	endtask

	// Stop offering samples and let every predicted result come back.
	task automatic wait_idle();
		sample_valid = 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		drains++;
	endtask

	// Result side: random stalls, steady stretches, and one long hold-off on request.
	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				result_ready = 1'b0;
				repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
				holdoff_req = 1'b0;
			end else if (stall > 0) begin
				result_ready = 1'b0;
				stall--;
			end else begin
				result_ready = 1'b1;
				if (!rx_steady)
					stall = idle_gap();
			end
		end
	end

	initial begin : stimulus
		int phase;
		int n;
		int gap;
		gae_in_t s;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values of both registers.
		apb_access(1'b0, REG_DISCOUNT, '0);
		apb_access(1'b0, REG_TRACE_DECAY, '0);

		// Directed samples: zeros, carries, saturation both ways, each flag, edge environments.
		send_sample(make_sample(0, '0, '0, '0, 1'b0, 1'b0, 1'b1), 0);
		send_sample(make_sample(0, 32'h0001_0000, '0, 32'h0002_0000, 1'b0, 1'b0, 1'b0), 0);
		send_sample(make_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0),
			0);
		send_sample(make_sample(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0),
			0);
		send_sample(make_sample(0, 32'h0000_8000, '0, '0, 1'b0, 1'b0, 1'b0), 0);
		send_sample(make_sample(1, 32'h0003_0000, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0),
			0);
		send_sample(make_sample(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0),
			0);
		send_sample(make_sample(1, 32'h7FFF_FFFF, '0, 32'h8000_0000, 1'b1, 1'b1, 1'b0), 0);
		send_sample(make_sample(2, 32'hFFFF_8000, 32'h0000_4000, 32'h0001_2345, 1'b0, 1'b0, 1'b1),
			0);
		send_sample(make_sample(2, 32'h0005_0000, 32'h0000_4000, 32'h0000_4000, 1'b0, 1'b0, 1'b0),
			0);
		send_sample(make_sample(2, 32'hFFFB_0000, 32'h0001_0000, 32'h0000_4000, 1'b0, 1'b0, 1'b0),
			0);
		send_sample(make_sample(15, 32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1), 0);
		send_sample(make_sample(15, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0),
			0);
		send_sample(make_sample(15, 32'h0001_0000, '0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1), 0);
		send_sample(make_sample(7, '1, '1, '1, 1'b0, 1'b0, 1'b0), 0);
		send_sample(make_sample(8, '0, '0, 32'h8000_0000, 1'b0, 1'b0, 1'b1), 0);
		send_sample(make_sample(8, '0, '0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0), 0);

		// Random phases, each under its own gamma and lambda.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				wait_idle();
				case (phase)
					1: set_gains(16'hFFFF, 16'hFFFF);
					2: set_gains(16'h0000, 16'h0000);
					3: set_gains(16'hFFFF, 16'h0000);
					4: set_gains(16'h0000, 16'hFFFF);
					5: set_gains(16'd65208, 16'd62259);
					default: set_gains(FRAC_W'($urandom), FRAC_W'($urandom));
				endcase
			end
			tx_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
			rx_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Long result hold-off while samples keep coming back to back.
				if (phase == 3 && n == PHASE_ITEMS / 2)
					holdoff_req = 1'b1;
				if (phase == 5 && n == PHASE_ITEMS / 2)
					wait_idle();
				if (tx_steady || (phase == 3 && n >= PHASE_ITEMS / 2 &&
						n < PHASE_ITEMS / 2 + BURST_ITEMS))
					gap = 0;
				else
					gap = idle_gap();
				s = ($urandom_range(0, 9) == 0) ? noise_sample() : rollout_sample();
				send_sample(s, gap);
			end
		end

		wait_idle();
		$display("Covered %0d samples (%0d results checked) over %0d gamma/lambda settings,",
			samples_sent, results_checked, settings_used);
		$display("with flag combinations, saturation, a %0d-cycle result hold-off and %0d drains.",
			HOLDOFF_CYCLES, drains);
		if (mismatch_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== gae_advantage_scan.f =====
hw/rtl/gae_pkg.sv
hw/rtl/gae_front.sv
hw/rtl/gae_queue.sv
hw/rtl/gae_back.sv
hw/rtl/gae_advantage_scan.sv
hw/rtl/gae_advantage_scan_checker.sv
verif/gae_advantage_scan_checker.sv
verif/gae_advantage_scan_tb.sv
